FILE: rtl/core/spq_pkg.sv
// Package for the sorted priority queue: sizes, status and operation codes,
// request/response structs and the per-cell entry and control types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PAYLOAD_BITS  = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                     operation;
    logic [PRIORITY_BITS-1:0] priority_req;
    logic [PAYLOAD_BITS-1:0]  payload;
  } in_req_t;

  typedef struct packed {
    status_t                  status;
    logic [PRIORITY_BITS-1:0] out_priority;
    logic [PAYLOAD_BITS-1:0]  out_payload;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_empty;
  } out_rsp_t;

  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [PAYLOAD_BITS-1:0]  pay;
  } entry_t;

  // Broadcast to every cell: insert the new entry, or shift toward the head
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with neighbors.
// Depends on spq_pkg for the entry and control types.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic                     clk,
  input  wire cell_ctl_t                ctl,
  input  wire logic                     occupied,
  input  wire logic [PRIORITY_BITS-1:0] new_prio,
  input  wire entry_t                   new_entry,
  input  wire logic                     left_keep,
  input  wire entry_t                   left_entry,
  input  wire entry_t                   right_entry,
  output logic                          keep,
  output entry_t                        entry
);

  entry_t entry_r;
  entry_t entry_nxt;

  // Stay put when the held entry ranks equal or above the new one
  assign keep  = occupied && (entry_r.prio >= new_prio);
  assign entry = entry_r;

  // Choose: hold, take the new entry, take the left entry, or take the right
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !keep) begin
      entry_nxt = left_keep ? new_entry : left_entry;
    end else if (ctl.del) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a row of spq_cell slots plus the
// fill count and the response register. Depends on spq_pkg and spq_cell.
//
// Usage: drive in_req and raise start for one cycle per request; a request is
// taken at each rising edge with start high and busy low. busy stays low, so
// a request may be issued every cycle. An enqueue (operation 0) places the
// entry behind every held entry of equal or higher priority; a dequeue
// (operation 1) removes and reports the head entry.
// Each request yields exactly one response on out_rsp, marked by out_valid for
// one cycle, in the cycle after the request was taken. Every cell compares its
// own priority with the new one and moves by at most one slot per request, so
// the whole row moves at the same clock edge as the count, whatever the fill.
// The response carries status (done, full so enqueue dropped, empty so nothing
// dequeued), the dequeued entry or zeros, the occupancy and an empty flag.
// The receiver cannot stall: a response not taken in its cycle is lost.
// Reset (rst_n low, synchronous) empties the queue and clears out_valid; the
// slot contents are not cleared, since only slots below the count are used.
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire in_req_t in_req,
  output logic         out_valid,
  output out_rsp_t     out_rsp
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_rsp_t         out_rsp_r;
  out_rsp_t         out_rsp_nxt;

  logic      accept;
  logic      is_full;
  logic      is_none;
  cell_ctl_t ctl;
  entry_t    new_entry;
  entry_t    cell_entry [DEPTH];
  logic      cell_keep  [DEPTH];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_full = (count_r == CNT_W'(DEPTH));
  assign is_none = (count_r == '0);

  assign new_entry.prio = in_req.priority_req;
  assign new_entry.pay  = in_req.payload;

  // Broadcast the move to the row; refused requests leave it untouched
  assign ctl.ins = accept && (in_req.operation == OP_ENQ) && !is_full;
  assign ctl.del = accept && (in_req.operation == OP_DEQ) && !is_none;

  // Build the row of slots, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_body
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (CNT_W'(i) < count_r),
      .new_prio    (in_req.priority_req),
      .new_entry   (new_entry),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .keep        (cell_keep[i]),
      .entry       (cell_entry[i])
    );
  end

  // Advance the count and form the response
  always_comb begin
    count_nxt   = count_r;
    out_rsp_nxt = '0;
    out_rsp_nxt.status = ST_DONE;
    if (in_req.operation == OP_ENQ) begin
      if (is_full) begin
        out_rsp_nxt.status = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (is_none) begin
        out_rsp_nxt.status = ST_EMPTY;
      end else begin
        count_nxt                = count_r - CNT_W'(1);
        out_rsp_nxt.out_priority = cell_entry[0].prio;
        out_rsp_nxt.out_payload  = cell_entry[0].pay;
      end
    end
    out_rsp_nxt.occupancy = count_nxt;
    out_rsp_nxt.is_empty  = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Hold the response payload from its strobe cycle until the next accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// Port-level checks for sorted_priority_queue, attached by bind below.
// Depends on spq_pkg for sizes and status codes.
`default_nettype none

module spq_checker import spq_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire in_req_t  in_req,
  input wire logic     out_valid,
  input wire out_rsp_t out_rsp
);

  // Every taken request gets its response in the next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("request taken without a response one cycle later");

  // No response without a request in the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("response without a request");

  // Empty flag agrees with occupancy
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.is_empty == (out_rsp.occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  // A refused request reports zeros and the boundary fill level
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status != ST_DONE) |->
      (out_rsp.out_priority == '0 && out_rsp.out_payload == '0 &&
       ((out_rsp.status == ST_FULL && out_rsp.occupancy == CNT_W'(DEPTH)) ||
        (out_rsp.status == ST_EMPTY && out_rsp.occupancy == '0))))
    else $error("refused request reports wrong entry or occupancy");

  // A successful enqueue after a full report cannot happen without a dequeue
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_FULL && start && !busy &&
     in_req.operation == OP_ENQ) |=> (out_rsp.status == ST_FULL))
    else $error("enqueue accepted into a full queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for sorted_priority_queue: random and directed
// enqueue/dequeue requests checked against an in-bench sorted-queue predictor.
// Depends on spq_pkg and the sorted_priority_queue RTL.

import spq_pkg::*;

// Tracks the queue contents and the responses still owed by the block
class spq_scoreboard;
  entry_t   held [DEPTH];
  int       held_count;
  out_rsp_t owed_rsp [$];
  int       mismatches;
  int       requests;
  int       checked;
  int       enq_done;
  int       enq_full;
  int       deq_done;
  int       deq_empty;

  function new();
    held_count = 0;
    mismatches = 0;
    requests   = 0;
    checked    = 0;
    enq_done   = 0;
    enq_full   = 0;
    deq_done   = 0;
    deq_empty  = 0;
  endfunction

  function int pending();
    return owed_rsp.size();
  endfunction

  // Apply one accepted request to the predicted queue and queue its response
  function void note_request(in_req_t req);
    out_rsp_t rsp;
    entry_t   ent;
    int       pos;
    rsp.status       = ST_DONE;
    rsp.out_priority = '0;
    rsp.out_payload  = '0;
    requests++;
    if (req.operation == OP_ENQ) begin
      if (held_count >= DEPTH) begin
        rsp.status = ST_FULL;
        enq_full++;
      end else begin
        // Place behind every entry of equal or higher priority
        pos = 0;
        while (pos < held_count && held[pos].prio >= req.priority_req)
          pos++;
        for (int k = held_count; k > pos; k--)
          held[k] = held[k-1];
        ent.prio  = req.priority_req;
        ent.pay   = req.payload;
        held[pos] = ent;
        held_count++;
        enq_done++;
      end
    end else begin
      if (held_count == 0) begin
        rsp.status = ST_EMPTY;
        deq_empty++;
      end else begin
        // Pop the head and shift the rest toward it
        rsp.out_priority = held[0].prio;
        rsp.out_payload  = held[0].pay;
        for (int k = 1; k < held_count; k++)
          held[k-1] = held[k];
        held_count--;
        deq_done++;
      end
    end
    rsp.occupancy = held_count[CNT_W-1:0];
    rsp.is_empty  = (held_count == 0);
    owed_rsp.push_back(rsp);
  endfunction

  // Compare one response against the oldest owed response
  function void check_response(out_rsp_t got);
    out_rsp_t want;
    if (owed_rsp.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected response status=%0d prio=%0h pay=%0h occ=%0d empty=%0b",
                 $time, got.status, got.out_priority, got.out_payload, got.occupancy,
                 got.is_empty);
      return;
    end
    want = owed_rsp.pop_front();
    checked++;
    if (got.status !== want.status || got.out_priority !== want.out_priority ||
        got.out_payload !== want.out_payload || got.occupancy !== want.occupancy ||
        got.is_empty !== want.is_empty) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: response mismatch on check %0d", $time, checked);
        $display("  expected status=%0d prio=%0h pay=%0h occ=%0d empty=%0b",
                 want.status, want.out_priority, want.out_payload, want.occupancy,
                 want.is_empty);
        $display("  actual   status=%0d prio=%0h pay=%0h occ=%0d empty=%0b",
                 got.status, got.out_priority, got.out_payload, got.occupancy,
                 got.is_empty);
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1500;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;

  spq_scoreboard sb;
  bit            allow_idle;

  sorted_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Note accepted requests first, then check any response on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_request(in_req);
      if (out_valid)
        sb.check_response(out_rsp);
    end
  end

  // Hold the request until the block takes it
  task automatic issue_request(input logic op, input logic [PRIORITY_BITS-1:0] prio,
                               input logic [PAYLOAD_BITS-1:0] pay);
    in_req_t req;
    req.operation    = op;
    req.priority_req = prio;
    req.payload      = pay;
    in_req <= req;
    start  <= 1'b1;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  // When idles are allowed, drop start for a short random gap before about 30 requests in a hundred
  task automatic maybe_idle();
    int gap;
    if (allow_idle && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 2);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mix of tie-heavy, extreme and full-range priorities
  function automatic logic [PRIORITY_BITS-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return PRIORITY_BITS'($urandom_range(0, 255));
      1: return PRIORITY_BITS'($urandom_range(0, 3));
      2: return PRIORITY_BITS'($urandom_range(252, 255));
      default: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    endcase
  endfunction

  // Stimulus
  initial begin
    int       enq_pct;
    int       waited;
    logic [7:0] mix_prio [4];
    mix_prio = '{8'h80, 8'h7f, 8'h01, 8'hfe};
    sb         = new();
    allow_idle = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dequeue, extremes and ties, fill to full, drop on full, dequeues
    issue_request(OP_DEQ, 8'hff, 16'hffff);
    issue_request(OP_ENQ, 8'h00, 16'h0000);
    issue_request(OP_ENQ, 8'hff, 16'hffff);
    issue_request(OP_ENQ, 8'h80, 16'h1234);
    issue_request(OP_ENQ, 8'h80, 16'h5678);
    issue_request(OP_ENQ, 8'h00, 16'h0001);
    issue_request(OP_ENQ, 8'hff, 16'h8000);
    for (int i = 0; i < DEPTH - 6; i++)
      issue_request(OP_ENQ, mix_prio[i % 4], 16'($urandom()));
    issue_request(OP_ENQ, 8'hff, 16'haaaa);
    repeat (3) issue_request(OP_DEQ, 8'h00, 16'h0000);

    // Random: phases that lean toward filling, draining, or neither
    enq_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 50;
        endcase
      end
      allow_idle = !(n >= 600 && n < 900);
      maybe_idle();
      if ($urandom_range(0, 99) < enq_pct)
        issue_request(OP_ENQ, pick_priority(), 16'($urandom()));
      else
        issue_request(OP_DEQ, 8'($urandom()), 16'($urandom()));
    end
    start <= 1'b0;

    // Drain outstanding responses, then let the pipe settle
    waited = 0;
    while (sb.pending() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);

    $display("Run: %0d requests, %0d responses checked, %0d mismatches",
             sb.requests, sb.checked, sb.mismatches);
    $display("Run: enqueues %0d taken / %0d dropped full, dequeues %0d taken / %0d on empty",
             sb.enq_done, sb.enq_full, sb.deq_done, sb.deq_empty);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      if (sb.pending() != 0)
        $display("%0d responses never arrived", sb.pending());
      $display("tb: FAIL");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2ms;
    $display("Timeout waiting for the block");
    $display("tb: FAIL");
    $finish;
  end

endmodule
